// ===== src/ubg_pkg.sv =====
// Package with the shared types, constants and helper function of the UTF-8 byte grouper.
package ubg_pkg;

	localparam int GROUP_MAX_BYTES = 4;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] MAX_CHARS_RESET = 8'd64;
	localparam logic [2:0] CONT_MAX = 3'(GROUP_MAX_BYTES - 1);

	typedef struct packed {
		logic [31:0] char_value;
		logic [7:0]  char_position;
		logic        is_line_end;
		logic        last;
	} res_t;

	function automatic logic [2:0] continuation_count(input logic [7:0] b);
		logic [2:0] count;
		logic       run;
		count = '0;
		run = 1'b1;
		for (int i = 6; i >= 0; i--) begin
			if (run && b[i]) begin
				count = count + 3'd1;
			end else begin
				run = 1'b0;
			end
		end
		if (count > CONT_MAX) begin
			count = CONT_MAX;
		end
		return count;
	endfunction

endpackage

// ===== src/ubg_byte_if.sv =====
// Channel interface that carries one text byte per item.
interface ubg_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

// ===== src/ubg_char_if.sv =====
// Channel interface that carries one grouped character or end-of-line marker per item.
interface ubg_char_if;
	logic        valid;
	logic        ready;
	logic [31:0] char_value;
	logic [7:0]  char_position;
	logic        is_line_end;
	logic        last;

	modport source (output valid, output char_value, output char_position,
		output is_line_end, output last, input ready);
	modport sink (input valid, input char_value, input char_position,
		input is_line_end, input last, output ready);
endinterface

// ===== src/ubg_cfg_if.sv =====
// Write channel interface for the line length limit register.
interface ubg_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] max_chars_per_line;

	modport source (output valid, output max_chars_per_line, input ready);
	modport sink (input valid, input max_chars_per_line, output ready);
endinterface

// ===== src/utf8_byte_grouper.sv =====
// The block takes one text byte per cycle into an input register, groups UTF-8 bytes into
// characters packed big-endian, and writes the up to two results each byte causes into a
// four-entry result queue that drains one item per cycle while char_out.ready is high. A byte
// is taken whenever the queue has room for two results, so the sustained rate is one byte per
// cycle as long as bytes cause one result on average and the output is not stalled; a byte's
// results pass from the input register into the result queue and are shown at the output.
// A newline flushes any open group and emits an end-of-line marker. Once a line holds
// max_chars_per_line characters, further bytes are ignored until the newline.
module utf8_byte_grouper (
	input logic clk,
	input logic arst_n,
	ubg_byte_if.sink text_in,
	ubg_char_if.source char_out,
	ubg_cfg_if.sink cfg
);
	import ubg_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] group_q;
	logic [2:0]  held_q;
	logic [2:0]  expected_q;
	logic [7:0]  chars_q;
	logic [7:0]  max_q;

	res_t        fifo_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  cnt_q;

	logic        advance;
	logic        pop;
	logic [1:0]  n_v;
	res_t        r0_v;
	res_t        r1_v;
	logic [31:0] group_d;
	logic [2:0]  held_d;
	logic [2:0]  expected_d;
	logic [7:0]  chars_d;
	logic [31:0] shifted;
	logic [2:0]  held_inc;
	logic        is_ascii;
	logic        is_lead;

	assign advance = valid_s1 && (cnt_q <= 3'd2);
	assign pop = char_out.valid && char_out.ready;
	assign text_in.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign is_ascii = !byte_s1[7];
	assign is_lead = byte_s1[7] && byte_s1[6];
	assign shifted = {group_q[23:0], byte_s1};
	assign held_inc = held_q + 3'd1;

	always_comb begin
		n_v = '0;
		r0_v = '0;
		r1_v = '0;
		group_d = group_q;
		held_d = held_q;
		expected_d = expected_q;
		chars_d = chars_q;
		if (byte_s1 == NEWLINE_BYTE) begin
			if (held_q != 3'd0 && chars_q < max_q) begin
				r0_v = '{char_value: group_q, char_position: chars_q, is_line_end: 1'b0,
					last: 1'b0};
				r1_v = '{char_value: '0, char_position: chars_q + 8'd1, is_line_end: 1'b1,
					last: 1'b1};
				n_v = 2'd2;
			end else begin
				r0_v = '{char_value: '0, char_position: chars_q, is_line_end: 1'b1,
					last: 1'b1};
				n_v = 2'd1;
			end
			group_d = '0;
			held_d = '0;
			expected_d = '0;
			chars_d = '0;
		end else if (chars_q < max_q) begin
			if ((is_ascii || is_lead) && held_q != 3'd0) begin
				r0_v = '{char_value: group_q, char_position: chars_q, is_line_end: 1'b0,
					last: 1'b1};
				n_v = 2'd1;
				chars_d = chars_q + 8'd1;
				group_d = '0;
				held_d = '0;
				expected_d = '0;
			end
			if (chars_d < max_q) begin
				if (is_ascii || (!is_lead && held_q == 3'd0)) begin
					if (n_v == 2'd0) begin
						r0_v = '{char_value: {24'd0, byte_s1}, char_position: chars_d,
							is_line_end: 1'b0, last: 1'b1};
						n_v = 2'd1;
					end else begin
						r0_v.last = 1'b0;
						r1_v = '{char_value: {24'd0, byte_s1}, char_position: chars_d,
							is_line_end: 1'b0, last: 1'b1};
						n_v = 2'd2;
					end
					chars_d = chars_d + 8'd1;
				end else if (is_lead) begin
					group_d = {24'd0, byte_s1};
					held_d = 3'd1;
					expected_d = continuation_count(byte_s1);
				end else begin
					if (held_q >= expected_q) begin
						r0_v = '{char_value: shifted, char_position: chars_q,
							is_line_end: 1'b0, last: 1'b1};
						n_v = 2'd1;
						chars_d = chars_q + 8'd1;
						group_d = '0;
						held_d = '0;
						expected_d = '0;
					end else begin
						group_d = shifted;
						held_d = held_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			group_q <= '0;
			held_q <= '0;
			expected_q <= '0;
			chars_q <= '0;
			max_q <= MAX_CHARS_RESET;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (text_in.ready) begin
				valid_s1 <= text_in.valid;
			end
			if (cfg.valid && cfg.ready) begin
				max_q <= cfg.max_chars_per_line;
			end
			if (advance) begin
				group_q <= group_d;
				held_q <= held_d;
				expected_q <= expected_d;
				chars_q <= chars_d;
				wr_ptr_q <= wr_ptr_q + n_v;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (advance ? {1'b0, n_v} : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1 <= text_in.text_byte;
		end
		if (advance && n_v != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0_v;
		end
		if (advance && n_v == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1_v;
		end
	end

	assign char_out.valid = cnt_q != 3'd0;
	assign char_out.char_value = fifo_q[rd_ptr_q].char_value;
	assign char_out.char_position = fifo_q[rd_ptr_q].char_position;
	assign char_out.is_line_end = fifo_q[rd_ptr_q].is_line_end;
	assign char_out.last = fifo_q[rd_ptr_q].last;

endmodule

// ===== src/ubg_checker.sv =====
// Port-level checker for the UTF-8 byte grouper and the bind that attaches it.
module ubg_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_char_value,
	input logic        out_is_line_end,
	input logic        out_last
);

	// A stalled result keeps its valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its character value and end-of-line flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char_value) && $stable(out_is_line_end))
		else $error("result payload changed while stalled");

	// The end-of-line marker is always the final item a newline causes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_line_end |-> out_last)
		else $error("end-of-line marker not flagged last");

	// The end-of-line marker carries no character bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_line_end |-> out_char_value == 32'd0)
		else $error("end-of-line marker carries a nonzero value");

endmodule

bind utf8_byte_grouper ubg_port_checks u_ubg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(char_out.valid),
	.out_ready(char_out.ready),
	.out_char_value(char_out.char_value),
	.out_is_line_end(char_out.is_line_end),
	.out_last(char_out.last)
);

// ===== test/ubg_checker.sv =====
// Checker that predicts the grouped characters from the observed bytes and compares each result.
`timescale 1ns / 100ps
module ubg_checker (
	input logic clk,
	input logic arst_n,
	ubg_byte_if text_in,
	ubg_char_if char_out,
	ubg_cfg_if cfg,
	output int errors,
	output int pending,
	output int chars_seen,
	output int line_ends_seen
);
	import ubg_pkg::*;

	logic [31:0] group_bytes;
	logic [2:0]  held;
	logic [2:0]  conts_due;
	logic [7:0]  line_count;
	logic [7:0]  line_limit;
	res_t        expected_chars[$];

	function automatic logic [2:0] lead_conts(input logic [7:0] b);
		int ones;
		ones = 0;
		while (ones < 7 && b[6 - ones]) begin
			ones++;
		end
		if (ones > GROUP_MAX_BYTES - 1) begin
			ones = GROUP_MAX_BYTES - 1;
		end
		return 3'(ones);
	endfunction

	task automatic push_char(input logic [31:0] value, input logic line_end);
		res_t r;
		r.char_value = value;
		r.char_position = line_count;
		r.is_line_end = line_end;
		r.last = 1'b0;
		expected_chars.push_back(r);
		if (!line_end) begin
			line_count = line_count + 8'd1;
		end
	endtask

	task automatic flush_group();
		push_char(group_bytes, 1'b0);
		group_bytes = '0;
		held = '0;
		conts_due = '0;
	endtask

	task automatic group_byte(input logic [7:0] b);
		int   queued_before;
		logic is_ascii;
		logic is_lead;
		res_t r;
		queued_before = expected_chars.size();
		is_ascii = !b[7];
		is_lead = b[7] && b[6];
		if (b == NEWLINE_BYTE) begin
			if (held != 0 && line_count < line_limit) begin
				flush_group();
			end
			push_char(32'd0, 1'b1);
			group_bytes = '0;
			held = '0;
			conts_due = '0;
			line_count = '0;
		end else if (line_count < line_limit) begin
			if ((is_ascii || is_lead) && held != 0) begin
				flush_group();
			end
			if (line_count < line_limit) begin
				if (is_ascii) begin
					push_char({24'd0, b}, 1'b0);
				end else if (is_lead) begin
					group_bytes = {24'd0, b};
					held = 3'd1;
					conts_due = lead_conts(b);
				end else if (held != 0) begin
					group_bytes = {group_bytes[23:0], b};
					if (held >= conts_due) begin
						flush_group();
					end else begin
						held = held + 3'd1;
					end
				end else begin
					push_char({24'd0, b}, 1'b0);
				end
			end
		end
		if (expected_chars.size() > queued_before) begin
			r = expected_chars.pop_back();
			r.last = 1'b1;
			expected_chars.push_back(r);
		end
	endtask

	task automatic note_failure(input string what, input res_t want, input res_t got);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s: expected %h pos %0d eol %b last %b, got %h pos %0d eol %b last %b",
				$realtime, what, want.char_value, want.char_position, want.is_line_end, want.last,
				got.char_value, got.char_position, got.is_line_end, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			group_bytes = '0;
			held = '0;
			conts_due = '0;
			line_count = '0;
			line_limit = MAX_CHARS_RESET;
			expected_chars.delete();
			errors = 0;
			pending = 0;
			chars_seen = 0;
			line_ends_seen = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				line_limit = cfg.max_chars_per_line;
			end
			if (text_in.valid && text_in.ready) begin
				group_byte(text_in.text_byte);
			end
			if (char_out.valid && char_out.ready) begin
				got.char_value = char_out.char_value;
				got.char_position = char_out.char_position;
				got.is_line_end = char_out.is_line_end;
				got.last = char_out.last;
				if (got.is_line_end === 1'b1) begin
					line_ends_seen++;
				end else begin
					chars_seen++;
				end
				if (expected_chars.size() == 0) begin
					note_failure("Unexpected item", '0, got);
				end else begin
					want = expected_chars.pop_front();
					if (got.char_value !== want.char_value
							|| got.char_position !== want.char_position
							|| got.is_line_end !== want.is_line_end
							|| got.last !== want.last) begin
						note_failure("Mismatch", want, got);
					end
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

// ===== test/tb_utf8_byte_grouper.sv =====
// Testbench top that drives text bytes and limit writes into the UTF-8 byte grouper.
`timescale 1ns / 100ps
module tb_utf8_byte_grouper;
	import ubg_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [7:0] GROUPING_BYTES[18] = '{
		8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF,
		8'h80, 8'hBF, 8'hBF, 8'h80, 8'hE2, 8'h41, 8'hC0, 8'hF8, 8'h0A
	};
	localparam logic [7:0] LIMIT_BYTES[5] = '{8'h41, 8'hC3, 8'hC4, 8'h42, 8'h0A};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle_count = 0;
	int   bytes_sent = 0;
	int   limit_writes = 0;
	int   burst_left = 0;
	int   hold_requests = 0;
	logic no_gaps = 1'b0;
	int   errors;
	int   pending;
	int   chars_seen;
	int   line_ends_seen;

	ubg_byte_if text_in();
	ubg_char_if char_out();
	ubg_cfg_if  cfg();

	utf8_byte_grouper dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.char_out(char_out),
		.cfg(cfg)
	);

	ubg_checker char_check (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.char_out(char_out),
		.cfg(cfg),
		.errors(errors),
		.pending(pending),
		.chars_seen(chars_seen),
		.line_ends_seen(line_ends_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int mode;
		int span;
		int holds_done;
		char_out.ready = 1'b0;
		mode = 0;
		span = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				char_out.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(20, 200);
				end
				span--;
				case (mode)
					0: char_out.ready <= 1'b1;
					1: char_out.ready <= 1'($urandom_range(0, 1));
					2: char_out.ready <= ($urandom_range(0, 9) != 0);
					default: char_out.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				text_in.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		text_in.valid <= 1'b1;
		text_in.text_byte <= b;
		@(posedge clk);
		while (!text_in.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		text_in.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		wait_drained();
		cfg.max_chars_per_line <= value;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg.valid <= 1'b0;
		limit_writes++;
	endtask

	task automatic send_text(input int count, input int line_max);
		int         sent_at_start;
		int         line_len;
		int         line_target;
		int         pick;
		int         conts;
		int         n;
		logic [7:0] b;
		sent_at_start = bytes_sent;
		line_len = 0;
		line_target = $urandom_range(0, line_max);
		while (bytes_sent - sent_at_start < count) begin
			pick = $urandom_range(0, 99);
			if (line_len >= line_target) begin
				send_byte(NEWLINE_BYTE);
				line_len = 0;
				line_target = $urandom_range(0, line_max);
			end else if (pick < 8) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 12) begin
				send_byte(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 40) begin
				b = 8'($urandom_range(0, 8'h7F));
				send_byte(b == NEWLINE_BYTE ? 8'h20 : b);
				line_len++;
			end else begin
				conts = $urandom_range(1, 4);
				case (conts)
					1: b = 8'($urandom_range(8'hC0, 8'hDF));
					2: b = 8'($urandom_range(8'hE0, 8'hEF));
					3: b = 8'($urandom_range(8'hF0, 8'hF7));
					default: b = 8'($urandom_range(8'hF8, 8'hFF));
				endcase
				n = (conts > GROUP_MAX_BYTES - 1) ? GROUP_MAX_BYTES - 1 : conts;
				if (pick < 48) begin
					n = $urandom_range(0, n - 1);
				end
				send_byte(b);
				for (int i = 0; i < n; i++) begin
					send_byte(8'($urandom_range(8'h80, 8'hBF)));
				end
				line_len++;
			end
		end
	endtask

	initial begin
		logic [7:0] lim;
		text_in.valid = 1'b0;
		text_in.text_byte = '0;
		cfg.valid = 1'b0;
		cfg.max_chars_per_line = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (GROUPING_BYTES[i]) begin
			send_byte(GROUPING_BYTES[i]);
		end
		send_byte(8'h41);
		send_byte(8'h42);
		send_byte(8'hC3);
		write_limit(8'd2);
		send_byte(NEWLINE_BYTE);
		foreach (LIMIT_BYTES[i]) begin
			send_byte(LIMIT_BYTES[i]);
		end

		write_limit(8'd255);
		no_gaps = 1'b1;
		send_text(300, 300);
		no_gaps = 1'b0;

		write_limit(8'd1);
		send_text(150, 4);

		write_limit(8'd3);
		no_gaps = 1'b1;
		hold_requests++;
		send_text(250, 6);
		no_gaps = 1'b0;

		write_limit(MAX_CHARS_RESET);
		send_text(300, 80);

		for (int p = 0; p < 4; p++) begin
			lim = 8'($urandom_range(1, 255));
			write_limit(lim);
			if (p == 2) begin
				no_gaps = 1'b1;
				hold_requests++;
			end
			send_text(210, int'(lim) + 20);
			no_gaps = 1'b0;
		end

		wait_drained();
		$display("Sent %0d text bytes across %0d limit settings, limits 1 and 255 among them.",
			bytes_sent, limit_writes + 1);
		$display("Checked %0d characters and %0d line ends, with %0d long output stalls.",
			chars_seen, line_ends_seen, hold_requests);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
